// ===== src/wlfl_pkg.sv =====
// Shared types and constants of the work list and free list engine.
`default_nettype none
package wlfl_pkg;

   localparam int SLOT_W = 6;
   localparam int KIND_W = 4;
   localparam int DATA_W = 64;

   localparam logic [2:0] REQ_POP_FREE  = 3'd0;
   localparam logic [2:0] REQ_PUSH_FREE = 3'd1;
   localparam logic [2:0] REQ_PUSH_WORK = 3'd2;
   localparam logic [2:0] REQ_POP_ALL   = 3'd3;
   localparam logic [2:0] REQ_FLUSH     = 3'd4;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_BAD_SLOT = 2'd2;

   typedef enum logic [2:0] {
      OP_POP_FREE,
      OP_PUSH_FREE,
      OP_PUSH_WORK,
      OP_POP_ALL,
      OP_FLUSH,
      OP_BAD
   } op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_WALK,
      S_FETCH,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [DATA_W-1:0] addr;
      logic [DATA_W-1:0] size;
   } entry_type;

   typedef struct packed {
      op_type            op;
      logic [SLOT_W-1:0] slot;
      logic              slot_ok;
      logic              kind_mw;
      logic              nowrap;
      logic [DATA_W-1:0] sum;
      entry_type         ent;
   } cmd_type;

endpackage
`default_nettype wire

// ===== src/wlfl_ram.sv =====
// Generic single write port RAM with registered, write-first read.
`default_nettype none
module wlfl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (we && waddr == raddr) begin
         rdata_ff <= wdata;
      end else begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

// ===== src/wlfl_front.sv =====
// Request intake: decodes each word and queues it for the back end.
`default_nettype none
module wlfl_front #(
   parameter int SLOTS = 64
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [2:0]                      req_type,
   input  wire logic [wlfl_pkg::SLOT_W-1:0]     req_slot,
   input  wire logic [wlfl_pkg::KIND_W-1:0]     req_kind,
   input  wire logic [wlfl_pkg::DATA_W-1:0]     req_addr,
   input  wire logic [wlfl_pkg::DATA_W-1:0]     req_size,
   input  wire logic [wlfl_pkg::KIND_W-1:0]     mem_write_code,
   output logic                                 q_valid,
   output wlfl_pkg::cmd_type                    q_cmd,
   input  wire logic                            q_pop
);
   import wlfl_pkg::*;

   cmd_type           q_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        cnt_ff, cnt_in;
   cmd_type           cmd;
   logic              push;
   logic [DATA_W:0]   sum_ext;

   always_comb begin
      sum_ext = {1'b0, req_addr} + {1'b0, req_size};
      case (req_type)
         REQ_POP_FREE:  cmd.op = OP_POP_FREE;
         REQ_PUSH_FREE: cmd.op = OP_PUSH_FREE;
         REQ_PUSH_WORK: cmd.op = OP_PUSH_WORK;
         REQ_POP_ALL:   cmd.op = OP_POP_ALL;
         REQ_FLUSH:     cmd.op = OP_FLUSH;
         default:       cmd.op = OP_BAD;
      endcase
      cmd.slot     = req_slot;
      cmd.slot_ok  = (req_slot != '0) && ({1'b0, req_slot} < (SLOT_W+1)'(SLOTS));
      cmd.kind_mw  = (req_kind == mem_write_code);
      cmd.nowrap   = !sum_ext[DATA_W];
      cmd.sum      = sum_ext[DATA_W-1:0];
      cmd.ent.kind = req_kind;
      cmd.ent.addr = req_addr;
      cmd.ent.size = req_size;
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_cmd     = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      cnt_in    = cnt_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd;
      end
   end
endmodule
`default_nettype wire

// ===== src/wlfl_back.sv =====
// List engine: executes queued requests against the slot stores.
`default_nettype none
module wlfl_back #(
   parameter int SLOTS = 64
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            q_valid,
   input  wire wlfl_pkg::cmd_type               q_cmd,
   output logic                                 q_pop,
   input  wire logic [wlfl_pkg::KIND_W-1:0]     mem_write_code,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [1:0]                           rsp_status,
   output logic [wlfl_pkg::SLOT_W-1:0]          rsp_out_slot,
   output logic [wlfl_pkg::KIND_W-1:0]          rsp_out_kind,
   output logic [wlfl_pkg::DATA_W-1:0]          rsp_out_addr,
   output logic [wlfl_pkg::DATA_W-1:0]          rsp_out_size,
   output logic                                 rsp_flush_seen,
   output logic                                 rsp_last
);
   import wlfl_pkg::*;

   localparam int IW = $clog2(SLOTS);
   localparam int EW = $bits(entry_type);

   state_type         state_ff, state_in;
   cmd_type           op_ff, op_in;
   logic [SLOT_W-1:0] work_head_ff, work_head_in;
   logic [SLOT_W-1:0] free_head_ff, free_head_in;
   logic              flush_ff, flush_in;
   logic [IW-1:0]     rd_addr_ff, rd_addr_in;
   logic [SLOT_W-1:0] prev_ff, prev_in;
   logic [IW-1:0]     cnt_ff, cnt_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        st_ff, st_in;
   logic [SLOT_W-1:0] oslot_ff, oslot_in;
   entry_type         oent_ff, oent_in;
   logic              ofl_ff, ofl_in;
   logic              olast_ff, olast_in;
   logic              rsp_load, out_free;

   logic              link_we;
   logic [IW-1:0]     link_waddr;
   logic [SLOT_W-1:0] link_wdata, link_rd;
   logic              data_we;
   logic [IW-1:0]     data_waddr;
   entry_type         data_wdata, data_rd;
   logic [EW-1:0]     data_rd_raw;
   logic              order_we;
   logic [IW-1:0]     order_raddr;
   logic [SLOT_W-1:0] order_rd;

   entry_type         hd;
   logic [DATA_W:0]   pend_ext;
   logic              merge;
   logic [SLOT_W-1:0] cur_slot;
   logic [IW-1:0]     cnt_inc;

   function automatic logic ok(input logic [SLOT_W-1:0] s);
      return (s != '0) && ({1'b0, s} < (SLOT_W+1)'(SLOTS));
   endfunction

   wlfl_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_link (
      .clock(clock), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
      .raddr(rd_addr_in), .rdata(link_rd)
   );

   wlfl_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_data (
      .clock(clock), .we(data_we), .waddr(data_waddr), .wdata(data_wdata),
      .raddr(rd_addr_in), .rdata(data_rd_raw)
   );

   // visit order of the pop all walk, replayed newest index first
   wlfl_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_order (
      .clock(clock), .we(order_we), .waddr(cnt_ff), .wdata(cur_slot),
      .raddr(order_raddr), .rdata(order_rd)
   );

   assign data_rd  = entry_type'(data_rd_raw);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign cur_slot = SLOT_W'(rd_addr_ff);
   assign cnt_inc  = cnt_ff + IW'(1);

   always_comb begin
      hd = (op_ff.slot == work_head_ff) ? op_ff.ent : data_rd;
      pend_ext = {1'b0, hd.addr} + {1'b0, hd.size};
      merge = op_ff.kind_mw && ok(work_head_ff) && op_ff.nowrap
              && (hd.kind == mem_write_code) && !pend_ext[DATA_W]
              && (op_ff.ent.addr == pend_ext[DATA_W-1:0]);
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      work_head_in = work_head_ff;
      free_head_in = free_head_ff;
      flush_in     = flush_ff;
      rd_addr_in   = rd_addr_ff;
      prev_in      = prev_ff;
      cnt_in       = cnt_ff;
      q_pop        = 1'b0;
      rsp_load     = 1'b0;
      st_in        = ST_OK;
      oslot_in     = '0;
      oent_in      = '0;
      ofl_in       = 1'b0;
      olast_in     = 1'b1;
      link_we      = 1'b0;
      link_waddr   = rd_addr_ff;
      link_wdata   = '0;
      data_we      = 1'b0;
      data_waddr   = op_ff.slot[IW-1:0];
      data_wdata   = op_ff.ent;
      order_we     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               op_in    = q_cmd;
               state_in = S_EXEC;
               case (q_cmd.op)
                  OP_POP_FREE:             rd_addr_in = free_head_ff[IW-1:0];
                  OP_PUSH_WORK, OP_POP_ALL: rd_addr_in = work_head_ff[IW-1:0];
                  default:                 rd_addr_in = rd_addr_ff;
               endcase
            end
         end
         S_EXEC: begin
            if (op_ff.op == OP_POP_ALL && ok(work_head_ff) && !flush_ff) begin
               work_head_in = '0;
               prev_in      = '0;
               cnt_in       = '0;
               state_in     = S_WALK;
            end else if (out_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
               case (op_ff.op)
                  OP_POP_FREE: begin
                     if (!ok(free_head_ff)) begin
                        st_in = ST_EMPTY;
                     end else begin
                        free_head_in = ok(link_rd) ? link_rd : '0;
                        link_we      = 1'b1;
                        link_wdata   = '0;
                        oslot_in     = free_head_ff;
                     end
                  end
                  OP_PUSH_FREE: begin
                     if (!op_ff.slot_ok) begin
                        st_in = ST_BAD_SLOT;
                     end else begin
                        link_we      = 1'b1;
                        link_waddr   = op_ff.slot[IW-1:0];
                        link_wdata   = free_head_ff;
                        free_head_in = op_ff.slot;
                     end
                  end
                  OP_PUSH_WORK: begin
                     if (!op_ff.slot_ok) begin
                        st_in = ST_BAD_SLOT;
                     end else begin
                        data_we = 1'b1;
                        if (flush_ff) begin
                           oslot_in = op_ff.slot;
                        end else begin
                           link_we      = 1'b1;
                           link_waddr   = op_ff.slot[IW-1:0];
                           work_head_in = op_ff.slot;
                           if (merge) begin
                              data_wdata.addr = hd.addr;
                              data_wdata.size = op_ff.sum - hd.addr;
                              link_wdata      = link_rd;
                              oslot_in        = work_head_ff;
                           end else begin
                              link_wdata = work_head_ff;
                              st_in      = ST_EMPTY;
                           end
                        end
                     end
                  end
                  OP_POP_ALL: begin
                     work_head_in = '0;
                     flush_in     = 1'b0;
                     ofl_in       = flush_ff;
                     if (!ok(work_head_ff)) begin
                        st_in = ST_EMPTY;
                     end else begin
                        oslot_in = work_head_ff;
                        oent_in  = data_rd;
                     end
                  end
                  OP_FLUSH: flush_in = 1'b1;
                  default:  st_in = ST_EMPTY;
               endcase
            end
         end
         S_WALK: begin
            link_we    = 1'b1;
            link_wdata = prev_ff;
            order_we   = 1'b1;
            prev_in    = cur_slot;
            cnt_in     = cnt_inc;
            if (ok(link_rd) && ({1'b0, cnt_inc} < (IW+1)'(SLOTS - 1))) begin
               rd_addr_in = link_rd[IW-1:0];
            end else begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            rd_addr_in = order_rd[IW-1:0];
            state_in   = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_load = 1'b1;
               oslot_in = cur_slot;
               oent_in  = data_rd;
               olast_in = (cnt_ff == IW'(1));
               cnt_in   = cnt_ff - IW'(1);
               if (cnt_ff == IW'(1)) begin
                  state_in = S_IDLE;
               end else begin
                  state_in = S_FETCH;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      order_raddr  = cnt_in - IW'(1);
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         work_head_ff <= '0;
         free_head_ff <= '0;
         flush_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         work_head_ff <= work_head_in;
         free_head_ff <= free_head_in;
         flush_ff     <= flush_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff      <= op_in;
      rd_addr_ff <= rd_addr_in;
      prev_ff    <= prev_in;
      cnt_ff     <= cnt_in;
      if (rsp_load) begin
         st_ff    <= st_in;
         oslot_ff <= oslot_in;
         oent_ff  <= oent_in;
         ofl_ff   <= ofl_in;
         olast_ff <= olast_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = st_ff;
   assign rsp_out_slot   = oslot_ff;
   assign rsp_out_kind   = oent_ff.kind;
   assign rsp_out_addr   = oent_ff.addr;
   assign rsp_out_size   = oent_ff.size;
   assign rsp_flush_seen = ofl_ff;
   assign rsp_last       = olast_ff;

   a_walk_exit: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WALK |=> state_ff == S_WALK || state_ff == S_FETCH)
      else $error("walk left to a wrong state");
   a_emit_cnt: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT |-> cnt_ff != '0)
      else $error("emit with zero count");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT && rsp_load && olast_in |=> state_ff == S_IDLE)
      else $error("last word did not end the walk");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == S_IDLE && q_valid)
      else $error("queue popped outside idle");
endmodule
`default_nettype wire

// ===== src/work_list_free_list_engine_core.sv =====
// Top level of the work list and free list engine.
// Usage: the req channel takes one request word (type, slot, kind, addr,
// size) at an edge with req_valid high and req_stall low. A two-entry queue
// holds words until the list engine is free. Each request gives one or more
// rsp words; rsp_last marks the final word of a request.
// csr_we writes the memory-write kind code from csr_wdata; write it only
// while no request is pending.
// Pop all walks the chain one slot per cycle to reverse its links and note
// the visit order, then emits the slots one at a time (order read, then
// store read); the registered store reads come before each slot's rsp word.
// Reset clears the list heads, flush flag, queue and output register; the
// slot stores are undefined until written and need no clearing pass.
// When the receiver stalls, the rsp word holds and the engine waits; the
// queue keeps accepting until full.
`default_nettype none
module work_list_free_list_engine_core #(
   parameter int SLOTS = 64
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [2:0]                      req_type,
   input  wire logic [wlfl_pkg::SLOT_W-1:0]     req_slot,
   input  wire logic [wlfl_pkg::KIND_W-1:0]     req_kind,
   input  wire logic [wlfl_pkg::DATA_W-1:0]     req_addr,
   input  wire logic [wlfl_pkg::DATA_W-1:0]     req_size,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [1:0]                           rsp_status,
   output logic [wlfl_pkg::SLOT_W-1:0]          rsp_out_slot,
   output logic [wlfl_pkg::KIND_W-1:0]          rsp_out_kind,
   output logic [wlfl_pkg::DATA_W-1:0]          rsp_out_addr,
   output logic [wlfl_pkg::DATA_W-1:0]          rsp_out_size,
   output logic                                 rsp_flush_seen,
   output logic                                 rsp_last,
   input  wire logic                            csr_we,
   input  wire logic [wlfl_pkg::KIND_W-1:0]     csr_wdata
);
   import wlfl_pkg::*;

   logic [KIND_W-1:0] mwc_ff;
   logic              q_valid, q_pop;
   cmd_type           q_cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         mwc_ff <= '0;
      end else if (csr_we) begin
         mwc_ff <= csr_wdata;
      end
   end

   wlfl_front #(.SLOTS(SLOTS)) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_type(req_type), .req_slot(req_slot), .req_kind(req_kind),
      .req_addr(req_addr), .req_size(req_size),
      .mem_write_code(mwc_ff),
      .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
   );

   wlfl_back #(.SLOTS(SLOTS)) u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop),
      .mem_write_code(mwc_ff),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_out_slot(rsp_out_slot),
      .rsp_out_kind(rsp_out_kind), .rsp_out_addr(rsp_out_addr),
      .rsp_out_size(rsp_out_size), .rsp_flush_seen(rsp_flush_seen),
      .rsp_last(rsp_last)
   );
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench of the work list and free list engine.
`default_nettype none
module tb_top;
   import wlfl_pkg::*;

   localparam int NSLOT = 64;

   typedef struct {
      logic [2:0]        rtype;
      logic [SLOT_W-1:0] slot;
      logic [KIND_W-1:0] kind;
      logic [DATA_W-1:0] addr;
      logic [DATA_W-1:0] size;
   } req_word;

   typedef struct {
      logic [1:0]        status;
      logic [SLOT_W-1:0] slot;
      logic [KIND_W-1:0] kind;
      logic [DATA_W-1:0] addr;
      logic [DATA_W-1:0] size;
      logic              flush_seen;
      logic              last;
   } rsp_word;

   class work_list_scoreboard;
      logic [SLOT_W-1:0] links[NSLOT];
      logic [KIND_W-1:0] kinds[NSLOT];
      logic [DATA_W-1:0] addrs[NSLOT];
      logic [DATA_W-1:0] sizes[NSLOT];
      logic [SLOT_W-1:0] work_head = '0;
      logic [SLOT_W-1:0] free_head = '0;
      logic              flush_flag = 1'b0;
      logic [KIND_W-1:0] mw_code = '0;
      rsp_word           expected_rsp[$];
      int                errors = 0;

      function void add(logic [1:0] st, logic [SLOT_W-1:0] sl, logic [KIND_W-1:0] kd,
                        logic [DATA_W-1:0] ad, logic [DATA_W-1:0] sz, logic fl, logic lst);
         rsp_word w;
         w.status = st; w.slot = sl; w.kind = kd; w.addr = ad; w.size = sz;
         w.flush_seen = fl; w.last = lst;
         expected_rsp.push_back(w);
      endfunction

      function void note(req_word r);
         logic [SLOT_W-1:0] h, pos, prev, nx;
         logic [SLOT_W-1:0] order[$];
         logic [DATA_W-1:0] end_a, pend;
         logic              fl;
         h = '0;
         case (r.rtype)
            REQ_POP_FREE: begin
               h = free_head;
               if (h == 0) add(ST_EMPTY, 0, 0, 0, 0, 0, 1);
               else begin
                  free_head = links[h];
                  links[h] = '0;
                  add(ST_OK, h, 0, 0, 0, 0, 1);
               end
            end
            REQ_PUSH_FREE: begin
               if (r.slot == 0) add(ST_BAD_SLOT, 0, 0, 0, 0, 0, 1);
               else begin
                  links[r.slot] = free_head;
                  free_head = r.slot;
                  add(ST_OK, 0, 0, 0, 0, 0, 1);
               end
            end
            REQ_PUSH_WORK: begin
               if (r.slot == 0) add(ST_BAD_SLOT, 0, 0, 0, 0, 0, 1);
               else begin
                  kinds[r.slot] = r.kind;
                  addrs[r.slot] = r.addr;
                  sizes[r.slot] = r.size;
                  if (flush_flag) add(ST_OK, r.slot, 0, 0, 0, 0, 1);
                  else begin
                     h = work_head;
                     end_a = r.addr + r.size;
                     pend = addrs[h] + sizes[h];
                     if (r.kind == mw_code && h != 0 && end_a >= r.addr &&
                         kinds[h] == mw_code && pend >= addrs[h] && r.addr == pend) begin
                        links[r.slot] = links[h];
                        addrs[r.slot] = addrs[h];
                        sizes[r.slot] = end_a - addrs[h];
                        work_head = r.slot;
                        add(ST_OK, h, 0, 0, 0, 0, 1);
                     end else begin
                        links[r.slot] = h;
                        work_head = r.slot;
                        add(ST_EMPTY, 0, 0, 0, 0, 0, 1);
                     end
                  end
               end
            end
            REQ_POP_ALL: begin
               h = work_head;
               fl = flush_flag;
               work_head = '0;
               flush_flag = 1'b0;
               if (h == 0) add(ST_EMPTY, 0, 0, 0, 0, fl, 1);
               else if (fl) add(ST_OK, h, kinds[h], addrs[h], sizes[h], 1, 1);
               else begin
                  pos = h;
                  prev = '0;
                  while (pos != 0 && order.size() < NSLOT - 1) begin
                     nx = links[pos];
                     links[pos] = prev;
                     order.push_front(pos);
                     prev = pos;
                     pos = nx;
                  end
                  foreach (order[k])
                     add(ST_OK, order[k], kinds[order[k]], addrs[order[k]], sizes[order[k]],
                         0, k == order.size() - 1);
               end
            end
            REQ_FLUSH: begin
               flush_flag = 1'b1;
               add(ST_OK, 0, 0, 0, 0, 0, 1);
            end
            default: add(ST_EMPTY, 0, 0, 0, 0, 0, 1);
         endcase
      endfunction

      function void cmp(string name, logic [DATA_W-1:0] e, logic [DATA_W-1:0] a);
         if (e !== a) begin
            $error("%s mismatch: expected %0h actual %0h", name, e, a);
            errors++;
         end
      endfunction

      function void check(rsp_word a);
         rsp_word e;
         if (expected_rsp.size() == 0) begin
            $error("unexpected rsp word, slot %0d", a.slot);
            errors++;
            return;
         end
         e = expected_rsp.pop_front();
         cmp("status", e.status, a.status);
         cmp("out_slot", e.slot, a.slot);
         cmp("out_kind", e.kind, a.kind);
         cmp("out_addr", e.addr, a.addr);
         cmp("out_size", e.size, a.size);
         cmp("flush_seen", e.flush_seen, a.flush_seen);
         cmp("last", e.last, a.last);
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [2:0]        req_type = '0;
   logic [SLOT_W-1:0] req_slot = '0;
   logic [KIND_W-1:0] req_kind = '0;
   logic [DATA_W-1:0] req_addr = '0;
   logic [DATA_W-1:0] req_size = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [1:0]        rsp_status;
   logic [SLOT_W-1:0] rsp_out_slot;
   logic [KIND_W-1:0] rsp_out_kind;
   logic [DATA_W-1:0] rsp_out_addr;
   logic [DATA_W-1:0] rsp_out_size;
   logic              rsp_flush_seen;
   logic              rsp_last;
   logic              csr_we = 1'b0;
   logic [KIND_W-1:0] csr_wdata = '0;

   work_list_scoreboard sb = new();
   int hold_left = 0;
   int stall_pct = 0;
   int burst_left = 0;

   work_list_free_list_engine_core #(.SLOTS(NSLOT)) dut (.*);

   always #5 clock = ~clock;

   initial begin
      #50_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // receiver: stall pattern changes at random moments, plus the long hold-off
   always @(posedge clock) begin
      rsp_word w;
      if (!reset && rsp_valid && !rsp_stall) begin
         w.status = rsp_status; w.slot = rsp_out_slot; w.kind = rsp_out_kind;
         w.addr = rsp_out_addr; w.size = rsp_out_size;
         w.flush_seen = rsp_flush_seen; w.last = rsp_last;
         sb.check(w);
      end
      if ($urandom_range(63) == 0) stall_pct = $urandom_range(2) * 35;
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else
         rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task automatic send(logic [2:0] t, logic [SLOT_W-1:0] s, logic [KIND_W-1:0] k,
                       logic [DATA_W-1:0] a, logic [DATA_W-1:0] z);
      req_word r;
      r.rtype = t; r.slot = s; r.kind = k; r.addr = a; r.size = z;
      req_valid <= 1'b1;
      req_type <= t; req_slot <= s; req_kind <= k; req_addr <= a; req_size <= z;
      do @(posedge clock); while (req_stall);
      sb.note(r);
      if (burst_left == 0) begin
         burst_left = $urandom_range(12);
         if ($urandom_range(2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end else
         burst_left--;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_code(logic [KIND_W-1:0] v);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.mw_code = v;
   endtask

   function automatic logic [DATA_W-1:0] rnd64();
      return {$urandom, $urandom};
   endfunction

   task automatic random_item();
      int op;
      logic [SLOT_W-1:0] s;
      logic [KIND_W-1:0] k;
      logic [DATA_W-1:0] a, z;
      op = $urandom_range(99);
      s = ($urandom_range(29) == 0) ? 6'd0 : 6'($urandom_range(1, NSLOT - 1));
      k = ($urandom_range(1) == 0) ? sb.mw_code : 4'($urandom);
      case ($urandom_range(3))
         0: a = rnd64();
         1: a = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(255);
         default: a = {32'h0, $urandom};
      endcase
      z = ($urandom_range(7) == 0) ? rnd64() : 64'($urandom_range(4096));
      if (op < 45) begin
         if (sb.work_head != 0 && $urandom_range(9) < 5) begin
            k = sb.mw_code;
            a = sb.addrs[sb.work_head] + sb.sizes[sb.work_head];
         end
         send(REQ_PUSH_WORK, s, k, a, z);
      end else if (op < 57) send(REQ_POP_ALL, s, k, a, z);
      else if (op < 71) send(REQ_PUSH_FREE, s, k, a, z);
      else if (op < 85) send(REQ_POP_FREE, s, k, a, z);
      else if (op < 90) send(REQ_FLUSH, s, k, a, z);
      else if (op < 93) send(3'($urandom_range(5, 7)), s, k, a, z);
      else send(REQ_PUSH_WORK, s, sb.mw_code, rnd64(), rnd64());
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed
      send(REQ_POP_FREE, 0, 0, 0, 0);
      send(REQ_POP_ALL, 0, 0, 0, 0);
      send(REQ_FLUSH, 0, 0, 0, 0);
      // every slot from 1 up gets stored contents while flush holds them off the list
      for (int i = 1; i < NSLOT; i++)
         send(REQ_PUSH_WORK, 6'(i), 4'($urandom), rnd64(), rnd64());
      send(REQ_POP_ALL, 0, 0, 0, 0);
      send(REQ_PUSH_FREE, 0, 0, 0, 0);
      send(REQ_PUSH_WORK, 0, 4'hF, '1, '1);
      send(3'd5, 0, 0, 0, 0);
      send(3'd6, 6'h3F, 4'hF, '1, '1);
      send(3'd7, 0, 0, 0, 0);
      send(REQ_PUSH_FREE, 6'h3F, 0, 0, 0);
      send(REQ_PUSH_FREE, 6'd1, 0, 0, 0);
      send(REQ_POP_FREE, 0, 0, 0, 0);
      send(REQ_POP_FREE, 0, 0, 0, 0);
      send(REQ_POP_FREE, 0, 0, 0, 0);
      drain();
      write_code(4'hF);
      send(REQ_PUSH_WORK, 6'd1, 4'hF, 64'd100, 64'd50);
      send(REQ_PUSH_WORK, 6'd2, 4'hF, 64'd150, 64'd10);
      send(REQ_PUSH_WORK, 6'd3, 4'hF, 64'd160, 64'hFFFF_FFFF_FFFF_FFFF);
      send(REQ_PUSH_WORK, 6'd4, 4'h0, '1, 64'd0);
      send(REQ_POP_ALL, 0, 0, 0, 0);
      send(REQ_PUSH_WORK, 6'd5, 4'h1, 64'd7, 64'd8);
      send(REQ_FLUSH, 0, 0, 0, 0);
      send(REQ_PUSH_WORK, 6'd6, 4'hF, 64'd15, 64'd1);
      send(REQ_POP_ALL, 0, 0, 0, 0);
      send(REQ_POP_ALL, 0, 0, 0, 0);
      drain();

      // random phases under several code settings
      for (int ph = 0; ph < 4; ph++) begin
         write_code(ph == 0 ? 4'h0 : ph == 1 ? 4'hF : 4'($urandom));
         if (ph == 2) begin
            for (int i = 1; i < NSLOT; i++)
               send(REQ_PUSH_WORK, 6'(i), 4'($urandom), rnd64(), 64'($urandom_range(64)));
            hold_left = 400;
            send(REQ_POP_ALL, 0, 0, 0, 0);
            for (int i = 0; i < 8; i++) send(REQ_PUSH_FREE, 6'($urandom_range(1, 63)), 0, 0, 0);
         end
         for (int i = 0; i < 65; i++) begin
            random_item();
            if (i == 50 && ph == 1) drain();
         end
         drain();
      end

      repeat (200) @(posedge clock);
      if (sb.errors == 0 && sb.expected_rsp.size() == 0)
         $display("RESULT: OK");
      else begin
         if (sb.expected_rsp.size() != 0)
            $error("%0d expected rsp words never arrived", sb.expected_rsp.size());
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== files.f =====
src/wlfl_pkg.sv
src/wlfl_ram.sv
src/wlfl_front.sv
src/wlfl_back.sv
src/work_list_free_list_engine_core.sv
tb/tb_top.sv
